// ===== rtl/core/sgec_pkg.sv =====
// ----------------------------------------------------------------------------
// sgec_pkg
// Shared types, register codes and corner tables for the grid connectivity
// block.
// ----------------------------------------------------------------------------
package sgec_pkg;

  localparam int unsigned MAX_CELLS_PER_AXIS = 256;

  localparam int unsigned CNT_W   = 9;   // configured cell count
  localparam int unsigned IDX_W   = 8;   // cell index
  localparam int unsigned NODE_W  = 26;  // node index
  localparam int unsigned PLANE_W = 17;  // nodes or cells in one xy plane
  localparam int unsigned ZOFF_W  = 25;  // z times a plane size

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CELLS_PER_AXIS);

  // configuration register indexes
  localparam logic [1:0] CFG_MODE    = 2'd0;
  localparam logic [1:0] CFG_CELLS_X = 2'd1;
  localparam logic [1:0] CFG_CELLS_Y = 2'd2;
  localparam logic [1:0] CFG_CELLS_Z = 2'd3;

  // element kinds
  localparam logic [2:0] MODE_LINE = 3'd0;
  localparam logic [2:0] MODE_QUAD = 3'd1;
  localparam logic [2:0] MODE_TRI  = 3'd2;
  localparam logic [2:0] MODE_HEX  = 3'd3;
  localparam logic [2:0] MODE_TET  = 3'd4;
  localparam logic [2:0] MODE_PYR  = 3'd5;

  // corner codes: 0..7 hex corners (bit1 +y, bit2 +z, +x is bit0 xor bit1 in hex order)
  localparam logic [3:0] CORNER_APEX = 4'd8;
  localparam logic [3:0] CORNER_NONE = 4'hF;

  // geometry derived from the configuration registers
  typedef struct packed {
    logic [2:0]                    mode;
    logic [CNT_W-1:0]              cx;
    logic [CNT_W-1:0]              cy;
    logic [CNT_W-1:0]              cz;
    logic [CNT_W-1:0]              nx;
    logic [PLANE_W-1:0]            nxny;
    logic [PLANE_W-1:0]            cxcy;
    logic [NODE_W-1:0]             nnodes;
    logic [7:0][PLANE_W-1:0]       corner_off;
  } geom_t;

  // cell after the multiplier stage
  typedef struct packed {
    logic                valid;
    logic                bad;
    logic [2:0]          mode;
    logic [IDX_W-1:0]    x;
    logic [PLANE_W-1:0]  ynx;
    logic [ZOFF_W-1:0]   znxny;
    logic [PLANE_W-1:0]  ycx;
    logic [ZOFF_W-1:0]   zcxcy;
  } prod_t;

  function automatic logic [1:0] mode_dims(input logic [2:0] mode);
    logic [1:0] d;
    unique case (mode)
      MODE_LINE:          d = 2'd1;
      MODE_QUAD, MODE_TRI: d = 2'd2;
      default:            d = 2'd3;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] elem_count(input logic [2:0] mode);
    logic [2:0] n;
    unique case (mode)
      MODE_TRI:           n = 3'd2;
      MODE_TET, MODE_PYR: n = 3'd6;
      default:            n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] corner_count(input logic [2:0] mode);
    logic [3:0] n;
    unique case (mode)
      MODE_LINE: n = 4'd2;
      MODE_QUAD: n = 4'd4;
      MODE_TRI:  n = 4'd3;
      MODE_HEX:  n = 4'd8;
      MODE_TET:  n = 4'd4;
      MODE_PYR:  n = 4'd5;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  // corner code of slot k of element elem; nibble k of each row is slot k
  function automatic logic [3:0] corner_code(input logic [2:0] mode,
                                             input logic [2:0] elem,
                                             input logic [2:0] k);
    logic [31:0] row;
    row = 32'hFFFF_FFFF;
    unique case (mode)
      MODE_LINE: row = 32'hFFFF_FF10;
      MODE_QUAD: row = 32'hFFFF_3210;
      MODE_TRI:  row = (elem == 3'd0) ? 32'hFFFF_F320 : 32'hFFFF_F210;
      MODE_HEX:  row = 32'h7654_3210;
      MODE_TET: begin
        case (elem)
          3'd0:    row = 32'hFFFF_4320;
          3'd1:    row = 32'hFFFF_6432;
          3'd2:    row = 32'hFFFF_7643;
          3'd3:    row = 32'hFFFF_5210;
          3'd4:    row = 32'hFFFF_5420;
          default: row = 32'hFFFF_6542;
        endcase
      end
      MODE_PYR: begin
        case (elem)
          3'd0:    row = 32'hFFF8_3210;
          3'd1:    row = 32'hFFF8_6745;
          3'd2:    row = 32'hFFF8_2651;
          3'd3:    row = 32'hFFF8_7304;
          3'd4:    row = 32'hFFF8_0154;
          default: row = 32'hFFF8_7623;
        endcase
      end
      default:   row = 32'hFFFF_FFFF;
    endcase
    return row[{k, 2'b00} +: 4];
  endfunction

endpackage

// ===== rtl/core/sgec_cfg.sv =====
// ----------------------------------------------------------------------------
// sgec_cfg
// Configuration registers and the plane sizes and corner offsets derived
// from them, with a settle count that covers the derivation stages.
// ----------------------------------------------------------------------------
module sgec_cfg
  import sgec_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_wdata,
  output geom_t            geom,
  output logic             settling
);

  logic [2:0]         mode_r;
  logic [CNT_W-1:0]   cells_x_r, cells_y_r, cells_z_r;
  logic [CNT_W-1:0]   cx, cy, cz;
  logic [CNT_W-1:0]   nx_r, nz_r;
  logic [PLANE_W-1:0] nxny_r, cxcy_r;
  logic [NODE_W-1:0]  nnodes_r;
  logic [7:0][PLANE_W-1:0] off_r, off_nxt;
  logic [1:0]         settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_HEX;
      cells_x_r <= CNT_W'(1);
      cells_y_r <= CNT_W'(1);
      cells_z_r <= CNT_W'(1);
      settle_r  <= 2'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE:    mode_r    <= cfg_wdata[2:0];
          CFG_CELLS_X: cells_x_r <= cfg_wdata;
          CFG_CELLS_Y: cells_y_r <= cfg_wdata;
          default:     cells_z_r <= cfg_wdata;
        endcase
        settle_r <= 2'd3;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // counts above the axis limit act as the limit
  assign cx = (cells_x_r > CNT_MAX) ? CNT_MAX : cells_x_r;
  assign cy = (cells_y_r > CNT_MAX) ? CNT_MAX : cells_y_r;
  assign cz = (cells_z_r > CNT_MAX) ? CNT_MAX : cells_z_r;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      off_nxt[c] = PLANE_W'(c[0] ^ c[1])
                 + (c[1] ? {8'd0, nx_r} : PLANE_W'(0))
                 + (c[2] ? nxny_r : PLANE_W'(0));
    end
  end

  // hex order: corners 2, 3, 6 and 7 are the +y ones, hence the xor above
  always_ff @(posedge clk) begin
    nx_r     <= cx + CNT_W'(1);
    nz_r     <= cz + CNT_W'(1);
    nxny_r   <= {8'd0, cx + CNT_W'(1)} * {8'd0, cy + CNT_W'(1)};
    cxcy_r   <= {8'd0, cx} * {8'd0, cy};
    nnodes_r <= {9'd0, nxny_r} * {17'd0, nz_r};
    off_r    <= off_nxt;
  end

  always_comb begin
    geom.mode       = mode_r;
    geom.cx         = cx;
    geom.cy         = cy;
    geom.cz         = cz;
    geom.nx         = nx_r;
    geom.nxny       = nxny_r;
    geom.cxcy       = cxcy_r;
    geom.nnodes     = nnodes_r;
    geom.corner_off = off_r;
  end

  assign settling = (settle_r != 2'd0);

endmodule

// ===== rtl/core/sgec_front.sv =====
// ----------------------------------------------------------------------------
// sgec_front
// Input register with the range check, then the multiplier stage that
// forms the row and plane terms of the node and apex indexes.
// ----------------------------------------------------------------------------
module sgec_front
  import sgec_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  geom_t            geom,
  input  logic             accept,
  input  logic [IDX_W-1:0] in_cell_x,
  input  logic [IDX_W-1:0] in_cell_y,
  input  logic [IDX_W-1:0] in_cell_z,
  input  logic             take,
  output prod_t            prod,
  output logic             stall
);

  logic             s1_v_r, s1_bad_r;
  logic [2:0]       s1_mode_r;
  logic [IDX_W-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic             s2_v_r;
  logic             s2_en;
  logic [1:0]       dims;
  logic [IDX_W-1:0] y_m, z_m;
  logic             bad;
  prod_t            s2_r;

  assign dims = mode_dims(geom.mode);
  assign y_m  = (dims >= 2'd2) ? in_cell_y : '0;
  assign z_m  = (dims == 2'd3) ? in_cell_z : '0;
  assign bad  = (geom.mode > MODE_PYR)
             || ({1'b0, in_cell_x} >= geom.cx)
             || ((dims >= 2'd2) && ({1'b0, in_cell_y} >= geom.cy))
             || ((dims == 2'd3) && ({1'b0, in_cell_z} >= geom.cz));

  assign s2_en = !s2_v_r || take;
  assign stall = s1_v_r && !s2_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s2_en) begin
        s1_v_r <= 1'b0;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bad_r  <= bad;
      s1_mode_r <= geom.mode;
      s1_x_r    <= in_cell_x;
      s1_y_r    <= y_m;
      s1_z_r    <= z_m;
    end
    if (s2_en) begin
      s2_r.valid <= s1_v_r;
      s2_r.bad   <= s1_bad_r;
      s2_r.mode  <= s1_mode_r;
      s2_r.x     <= s1_x_r;
      s2_r.ynx   <= {9'd0, s1_y_r} * {8'd0, geom.nx};
      s2_r.znxny <= {17'd0, s1_z_r} * {8'd0, geom.nxny};
      s2_r.ycx   <= {9'd0, s1_y_r} * {8'd0, geom.cx};
      s2_r.zcxcy <= {17'd0, s1_z_r} * {8'd0, geom.cxcy};
    end
  end

  always_comb begin
    prod       = s2_r;
    prod.valid = s2_v_r;
  end

endmodule

// ===== rtl/core/sgec_emit.sv =====
// ----------------------------------------------------------------------------
// sgec_emit
// Cell register with base and apex sums, element counter and the result
// register that sends one element word per cycle.
// ----------------------------------------------------------------------------
module sgec_emit
  import sgec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  geom_t             geom,
  input  prod_t             prod,
  output logic              take,
  output logic              out_valid,
  output logic [NODE_W-1:0] out_node_a,
  output logic [NODE_W-1:0] out_node_b,
  output logic [NODE_W-1:0] out_node_c,
  output logic [NODE_W-1:0] out_node_d,
  output logic [NODE_W-1:0] out_node_e,
  output logic [NODE_W-1:0] out_node_f,
  output logic [NODE_W-1:0] out_node_g,
  output logic [NODE_W-1:0] out_node_h,
  output logic [3:0]        out_corner_count,
  output logic [2:0]        out_sub_element,
  output logic              out_last,
  output logic              out_bad_cell
);

  logic              cell_v_r, cell_bad_r;
  logic [2:0]        cell_mode_r;
  logic [NODE_W-1:0] base_r, apex_r;
  logic [2:0]        elem_r;
  logic [2:0]        n_el;
  logic              last_now;

  logic                  out_valid_r, out_last_r, out_bad_r;
  logic [7:0][NODE_W-1:0] node_r, node_nxt;
  logic [3:0]            cnt_r;
  logic [2:0]            sub_r;

  assign n_el     = cell_bad_r ? 3'd1 : elem_count(cell_mode_r);
  assign last_now = cell_v_r && (elem_r == n_el - 3'd1);
  assign take     = !cell_v_r || last_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_v_r    <= 1'b0;
      elem_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cell_v_r;
      if (take) begin
        cell_v_r <= prod.valid;
        elem_r   <= 3'd0;
      end else begin
        elem_r   <= elem_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cell_bad_r  <= prod.bad;
      cell_mode_r <= prod.mode;
      base_r      <= {18'd0, prod.x} + {9'd0, prod.ynx} + {1'b0, prod.znxny};
      apex_r      <= geom.nnodes + {1'b0, prod.zcxcy} + {9'd0, prod.ycx}
                   + {18'd0, prod.x};
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      logic [3:0] code;
      code = corner_code(cell_mode_r, elem_r, 3'(k));
      if (cell_bad_r || code == CORNER_NONE) begin
        node_nxt[k] = '0;
      end else if (code == CORNER_APEX) begin
        node_nxt[k] = apex_r;
      end else begin
        node_nxt[k] = base_r + {9'd0, geom.corner_off[code[2:0]]};
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    cnt_r      <= cell_bad_r ? 4'd0 : corner_count(cell_mode_r);
    sub_r      <= cell_bad_r ? 3'd0 : elem_r;
    out_last_r <= last_now;
    out_bad_r  <= cell_bad_r;
  end

  assign out_valid        = out_valid_r;
  assign out_node_a       = node_r[0];
  assign out_node_b       = node_r[1];
  assign out_node_c       = node_r[2];
  assign out_node_d       = node_r[3];
  assign out_node_e       = node_r[4];
  assign out_node_f       = node_r[5];
  assign out_node_g       = node_r[6];
  assign out_node_h       = node_r[7];
  assign out_corner_count = cnt_r;
  assign out_sub_element  = sub_r;
  assign out_last         = out_last_r;
  assign out_bad_cell     = out_bad_r;

`ifndef SYNTHESIS
  a_no_gap_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("element words of one cell not contiguous");

  a_sub_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_sub_element == $past(out_sub_element) + 3'd1)
    else $error("sub_element did not advance by one");

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_cell |->
      out_last && out_corner_count == 4'd0 && out_sub_element == 3'd0)
    else $error("bad cell word malformed");
`endif

endmodule

// ===== rtl/core/structured_grid_element_connectivity.sv =====
// ----------------------------------------------------------------------------
// structured_grid_element_connectivity
// Turns one cell position of a regular grid into the node-index words of
// the elements that fill it.
// ----------------------------------------------------------------------------
// Usage: a cell is taken at a clock edge with start high and busy low. Its
// first element word comes out through the input, multiplier, cell and
// result registers, and the words of one cell follow back to back, out_valid
// high for exactly one cycle each; the receiver cannot stall, so it must
// take every word as it comes. A cell gives 1 word (line, quad, hexahedron),
// 2 (triangles) or 6 (tetrahedra, pyramids); a cell outside the counts, or
// an undefined mode, gives one word with out_bad_cell set. The output side
// sends one element word per cycle while it holds a cell, the next cell
// entering while the last word of the previous one is built. After any
// cfg_we the block holds busy while the plane sizes and corner offsets are
// recomputed; write configuration only when no words are still due.
// ----------------------------------------------------------------------------
module structured_grid_element_connectivity
  import sgec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata,
  // cell command
  input  logic              start,
  output logic              busy,
  input  logic [IDX_W-1:0]  in_cell_x,
  input  logic [IDX_W-1:0]  in_cell_y,
  input  logic [IDX_W-1:0]  in_cell_z,
  // element words
  output logic              out_valid,
  output logic [NODE_W-1:0] out_node_a,
  output logic [NODE_W-1:0] out_node_b,
  output logic [NODE_W-1:0] out_node_c,
  output logic [NODE_W-1:0] out_node_d,
  output logic [NODE_W-1:0] out_node_e,
  output logic [NODE_W-1:0] out_node_f,
  output logic [NODE_W-1:0] out_node_g,
  output logic [NODE_W-1:0] out_node_h,
  output logic [3:0]        out_corner_count,
  output logic [2:0]        out_sub_element,
  output logic              out_last,
  output logic              out_bad_cell
);

  geom_t geom;
  prod_t prod;
  logic  settling;
  logic  front_stall;
  logic  take;
  logic  accept;

  // busy is decoded from registers only; it drops as soon as the input
  // register can move on, even while earlier cells are still in flight
  assign busy   = settling || front_stall;
  assign accept = start && !busy;

  // registers, clamped counts, node/cell plane sizes, corner offsets
  sgec_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom),
    .settling  (settling)
  );

  // input register + range check, then y*NX, z*NX*NY, y*cx, z*cx*cy
  sgec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .accept    (accept),
    .in_cell_x (in_cell_x),
    .in_cell_y (in_cell_y),
    .in_cell_z (in_cell_z),
    .take      (take),
    .prod      (prod),
    .stall     (front_stall)
  );

  // base/apex sums, then one element word per cycle from the corner tables
  sgec_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .geom             (geom),
    .prod             (prod),
    .take             (take),
    .out_valid        (out_valid),
    .out_node_a       (out_node_a),
    .out_node_b       (out_node_b),
    .out_node_c       (out_node_c),
    .out_node_d       (out_node_d),
    .out_node_e       (out_node_e),
    .out_node_f       (out_node_f),
    .out_node_g       (out_node_g),
    .out_node_h       (out_node_h),
    .out_corner_count (out_corner_count),
    .out_sub_element  (out_sub_element),
    .out_last         (out_last),
    .out_bad_cell     (out_bad_cell)
  );

endmodule
